@@ hw/rtl/qtba_pkg.sv @@
package qtba_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned PARAM_COUNT_DEF = 7;
  localparam int unsigned BIN_COUNT_DEF   = 4096;

  // Field widths
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned VALUE_W   = 48;
  localparam int unsigned BIN_NUM_W = 12;
  localparam int unsigned CFG_IDX_W = 3;

  // Term width: c*ph (48 bits) plus floor(c*pl / 2^24) (33 bits)
  localparam int unsigned TERM_W = 49;

  // Queue depths between front and back, and in front of the result port
  localparam int unsigned TQ_DEPTH = 8;
  localparam int unsigned RQ_DEPTH = 2;

  // Second index that marks a linear term
  localparam logic [IDX_W-1:0] LINEAR_MARK = 3'd7;

  // Configuration register indexes (parameter values sit below this one)
  localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_CENTRAL = 3'd7;

  // 1.0 in Q24.24
  localparam logic signed [VALUE_W-1:0] ONE_Q24 = 48'sh0000_0100_0000;

  // One term beat travelling from front to back
  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic                     last;
  } term_beat_t;

  // One finished bin
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [BIN_NUM_W-1:0]      number;
    logic                      sat;
  } result_t;

endpackage

@@ hw/rtl/qtba_fifo.sv @@
module qtba_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Upstream flow control must never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("qtba_fifo: push while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (do_push && !do_pop) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("qtba_fifo: fill count did not follow a push");

endmodule

@@ hw/rtl/qtba_front.sv @@
module qtba_front #(
  parameter int unsigned PARAM_COUNT = qtba_pkg::PARAM_COUNT_DEF,
  parameter int unsigned QDEPTH      = qtba_pkg::TQ_DEPTH
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push,
  output logic                                    full,
  input  logic [qtba_pkg::IDX_W-1:0]              first_param_i,
  input  logic [qtba_pkg::IDX_W-1:0]              second_param_i,
  input  logic signed [qtba_pkg::COEF_W-1:0]      coefficient_i,
  input  logic                                    last_of_bin_i,
  input  logic signed [qtba_pkg::COEF_W-1:0]      param_i [PARAM_COUNT],
  output logic                                    tq_push_o,
  output qtba_pkg::term_beat_t                    tq_data_o,
  input  logic                                    tq_pop_i
);

  localparam int unsigned PIW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int unsigned CRW = $clog2(QDEPTH + 1);
  localparam int unsigned CW  = qtba_pkg::COEF_W;

  logic                 accept;
  logic                 is_linear;
  logic signed [CW-1:0] op_a, op_b;

  logic [CRW-1:0]       credit_q, credit_d;

  logic                 s1_vld_q, s2_vld_q, s3_vld_q;
  logic signed [CW-1:0] s1_a_q, s1_b_q, s1_coef_q, s2_coef_q;
  logic                 s1_lin_q, s2_lin_q, s3_lin_q;
  logic                 s1_last_q, s2_last_q, s3_last_q;
  logic signed [63:0]   s2_prod_q;
  logic signed [39:0]   prod_shr;
  logic signed [15:0]   prod_hi;
  logic [23:0]          prod_lo;
  logic signed [39:0]   s3_p_q;
  logic signed [47:0]   s3_hi_q;
  logic signed [56:0]   s3_lo_q;

  assign accept = push && !full;

  // Classify the item and pick operands: c*v[i] for linear, v[i]*v[j] otherwise
  always_comb begin
    is_linear = (second_param_i == qtba_pkg::LINEAR_MARK);
    op_a      = '0;
    op_b      = '0;
    if (32'(first_param_i) < PARAM_COUNT) begin
      op_a = param_i[first_param_i[PIW-1:0]];
    end
    if (is_linear) begin
      op_b = coefficient_i;
    end else if (32'(second_param_i) < PARAM_COUNT) begin
      op_b = param_i[second_param_i[PIW-1:0]];
    end
  end

  // Floor by 2^24 is the arithmetic shift; split p into high and low parts
  assign prod_shr = s2_prod_q[63:24];
  assign prod_hi  = prod_shr[39:24];
  assign prod_lo  = prod_shr[23:0];

  // Count items between the input and the back side of the queue
  always_comb begin
    credit_d = credit_q;
    if (accept && !tq_pop_i) begin
      credit_d = credit_q + CRW'(1);
    end else if (!accept && tq_pop_i) begin
      credit_d = credit_q - CRW'(1);
    end
  end

  assign full = (credit_q == CRW'(QDEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      credit_q <= credit_d;
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Multiplier pipeline: operands, first product, coefficient products
  always_ff @(posedge clk_i) begin
    s1_a_q    <= op_a;
    s1_b_q    <= op_b;
    s1_coef_q <= coefficient_i;
    s1_lin_q  <= is_linear;
    s1_last_q <= last_of_bin_i;

    s2_prod_q <= 64'(s1_a_q) * 64'(s1_b_q);
    s2_coef_q <= s1_coef_q;
    s2_lin_q  <= s1_lin_q;
    s2_last_q <= s1_last_q;

    s3_p_q    <= prod_shr;
    s3_hi_q   <= 48'(s2_coef_q) * 48'(prod_hi);
    s3_lo_q   <= 57'(s2_coef_q) * $signed({1'b0, prod_lo});
    s3_lin_q  <= s2_lin_q;
    s3_last_q <= s2_last_q;
  end

  // Form the term and hand it to the queue
  always_comb begin
    tq_push_o      = s3_vld_q;
    tq_data_o.last = s3_last_q;
    if (s3_lin_q) begin
      tq_data_o.term = qtba_pkg::TERM_W'(s3_p_q);
    end else begin
      tq_data_o.term = qtba_pkg::TERM_W'(s3_hi_q)
                     + qtba_pkg::TERM_W'($signed(s3_lo_q[56:24]));
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) credit_q <= CRW'(QDEPTH))
    else $error("qtba_front: credit count beyond queue depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $countones({s1_vld_q, s2_vld_q, s3_vld_q}) <= 32'(credit_q))
    else $error("qtba_front: beats in flight without credit");

endmodule

@@ hw/rtl/qtba_back.sv @@
module qtba_back #(
  parameter int unsigned BIN_COUNT = qtba_pkg::BIN_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 include_central_i,
  input  logic                 tq_empty_i,
  input  qtba_pkg::term_beat_t tq_data_i,
  output logic                 tq_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output qtba_pkg::result_t    res_data_o
);

  localparam int unsigned BCW   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int unsigned VW    = qtba_pkg::VALUE_W;
  localparam int unsigned SUM_W = VW + 2;

  logic signed [VW-1:0]    running_q, running_d;
  logic                    open_q, open_d;
  logic                    sat_q, sat_d;
  logic [BCW-1:0]          bin_q, bin_d;

  logic                    take;
  logic signed [VW-1:0]    base;
  logic signed [SUM_W-1:0] sum;
  logic                    ovf;
  logic signed [VW-1:0]    clamped;

  // Take a beat unless it closes a bin and the result queue is full
  assign take       = !tq_empty_i && (!tq_data_i.last || !res_full_i);
  assign tq_pop_o   = take;
  assign res_push_o = take && tq_data_i.last;

  // Accumulate with saturation to the Q24.24 range
  always_comb begin
    if (open_q) begin
      base = running_q;
    end else begin
      base = include_central_i ? qtba_pkg::ONE_Q24 : '0;
    end
    sum = SUM_W'(base) + SUM_W'(tq_data_i.term);
    ovf = (sum[SUM_W-1:VW-1] != {(SUM_W - VW + 1){sum[SUM_W-1]}});
    if (!ovf) begin
      clamped = sum[VW-1:0];
    end else if (sum[SUM_W-1]) begin
      clamped = {1'b1, {(VW - 1){1'b0}}};
    end else begin
      clamped = {1'b0, {(VW - 1){1'b1}}};
    end
  end

  always_comb begin
    running_d = running_q;
    open_d    = open_q;
    sat_d     = sat_q;
    bin_d     = bin_q;
    if (take) begin
      running_d = clamped;
      sat_d     = (open_q && sat_q) || ovf;
      open_d    = !tq_data_i.last;
      if (tq_data_i.last) begin
        bin_d = (bin_q == BCW'(BIN_COUNT - 1)) ? '0 : bin_q + BCW'(1);
      end
    end
  end

  always_comb begin
    res_data_o.value  = clamped;
    res_data_o.number = qtba_pkg::BIN_NUM_W'(bin_q);
    res_data_o.sat    = (open_q && sat_q) || ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      open_q    <= 1'b0;
      sat_q     <= 1'b0;
      bin_q     <= '0;
    end else begin
      running_q <= running_d;
      open_q    <= open_d;
      sat_q     <= sat_d;
      bin_q     <= bin_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (take && tq_data_i.last) |=> !open_q)
    else $error("qtba_back: bin still open after its last term");

endmodule

@@ hw/rtl/quadratic_term_bin_accumulator.sv @@
// Evaluates one quadratic polynomial per bin: a base of 1.0 or 0 plus c*v[i]
// for linear terms and c*v[i]*v[j] for quadratic and mixed terms, in signed
// Q8.24 with a saturating Q24.24 sum and a per-bin sticky saturation flag.
// Parameter values and the base choice are configuration registers, to be
// written only while no item is in flight. The block takes one coefficient
// per cycle while full is low. A term goes through a three-stage multiplier
// pipeline in the front, waits in an eight-entry term queue and is summed
// into a registered running value in the back. Results of closed bins wait
// in a two-entry queue, and full rises when eight items are between the
// input and the accumulator.
module quadratic_term_bin_accumulator #(
  parameter int unsigned PARAM_COUNT = qtba_pkg::PARAM_COUNT_DEF,
  parameter int unsigned BIN_COUNT   = qtba_pkg::BIN_COUNT_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [qtba_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [31:0]                             cfg_data_i,
  input  logic                                    push,
  output logic                                    full,
  input  logic [qtba_pkg::IDX_W-1:0]              first_param_i,
  input  logic [qtba_pkg::IDX_W-1:0]              second_param_i,
  input  logic signed [qtba_pkg::COEF_W-1:0]      coefficient_i,
  input  logic                                    last_of_bin_i,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [qtba_pkg::VALUE_W-1:0]     bin_value_o,
  output logic [qtba_pkg::BIN_NUM_W-1:0]          bin_number_o,
  output logic                                    saturated_o
);

  localparam int unsigned PIW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

  logic signed [qtba_pkg::COEF_W-1:0] param_q [PARAM_COUNT];
  logic                               include_central_q;
  logic                               cfg_write;

  qtba_pkg::term_beat_t tq_in, tq_out;
  logic                 tq_push, tq_pop, tq_full, tq_empty;
  qtba_pkg::result_t    rq_in, rq_out;
  logic                 rq_push, rq_full;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(PARAM_COUNT); i++) begin
        param_q[i] <= '0;
      end
      include_central_q <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_index_i == qtba_pkg::CFG_INCLUDE_CENTRAL) begin
        include_central_q <= cfg_data_i[0];
      end else if (32'(cfg_index_i) < PARAM_COUNT) begin
        param_q[cfg_index_i[PIW-1:0]] <= cfg_data_i;
      end
    end
  end

  qtba_front #(
    .PARAM_COUNT(PARAM_COUNT),
    .QDEPTH     (qtba_pkg::TQ_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .first_param_i (first_param_i),
    .second_param_i(second_param_i),
    .coefficient_i (coefficient_i),
    .last_of_bin_i (last_of_bin_i),
    .param_i       (param_q),
    .tq_push_o     (tq_push),
    .tq_data_o     (tq_in),
    .tq_pop_i      (tq_pop)
  );

  qtba_fifo #(
    .WIDTH($bits(qtba_pkg::term_beat_t)),
    .DEPTH(qtba_pkg::TQ_DEPTH)
  ) u_term_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (tq_push),
    .data_i (tq_in),
    .pop_i  (tq_pop),
    .data_o (tq_out),
    .full_o (tq_full),
    .empty_o(tq_empty)
  );

  qtba_back #(
    .BIN_COUNT(BIN_COUNT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .include_central_i(include_central_q),
    .tq_empty_i       (tq_empty),
    .tq_data_i        (tq_out),
    .tq_pop_o         (tq_pop),
    .res_full_i       (rq_full),
    .res_push_o       (rq_push),
    .res_data_o       (rq_in)
  );

  qtba_fifo #(
    .WIDTH($bits(qtba_pkg::result_t)),
    .DEPTH(qtba_pkg::RQ_DEPTH)
  ) u_result_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rq_push),
    .data_i (rq_in),
    .pop_i  (pop),
    .data_o (rq_out),
    .full_o (rq_full),
    .empty_o(empty)
  );

  assign bin_value_o  = rq_out.value;
  assign bin_number_o = rq_out.number;
  assign saturated_o  = rq_out.sat;

  // The credit count in the front keeps the term queue from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni) tq_push |-> !tq_full)
    else $error("quadratic_term_bin_accumulator: term queue overrun");

endmodule

@@ verif/tb.sv @@
module tb;

  localparam int unsigned PARAM_COUNT    = qtba_pkg::PARAM_COUNT_DEF;
  localparam int unsigned BIN_COUNT      = qtba_pkg::BIN_COUNT_DEF;
  localparam int          CLK_PERIOD     = 20;
  localparam int          DRAIN_CYCLES   = 24;
  localparam int          TIMEOUT_CYCLES = 400000;
  localparam int          FRAC_BITS      = 24;
  localparam int          MAX_BIN_TERMS  = 6;
  localparam int          FINAL_BINS     = 50;

  localparam longint SUM_MAX = (64'sd1 <<< 47) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< 47);

  localparam logic signed [qtba_pkg::COEF_W-1:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [qtba_pkg::COEF_W-1:0] Q_MAX     = 32'sh7fff_ffff;
  localparam logic signed [qtba_pkg::COEF_W-1:0] Q_ONE     = 32'sh0100_0000;
  localparam logic signed [qtba_pkg::COEF_W-1:0] Q_MINUS_1 = 32'shff00_0000;
  localparam logic signed [qtba_pkg::COEF_W-1:0] Q_LSB_NEG = 32'shffff_ffff;

  typedef logic [qtba_pkg::CFG_IDX_W-1:0] reg_idx_t;
  typedef logic [qtba_pkg::IDX_W-1:0]     param_idx_t;

  // Parameter value registers sit at the bottom of the register map
  localparam reg_idx_t CFG_PARAM_BASE = '0;

  // Kinds of parameter setting used by the random phases
  typedef enum int {SET_EXTREME, SET_SMALL, SET_WIDE} param_set_e;

  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                cfg_valid_i    = 1'b0;
  logic                                cfg_ready_o;
  reg_idx_t                            cfg_index_i    = '0;
  logic [31:0]                         cfg_data_i     = '0;
  logic                                push           = 1'b0;
  logic                                full;
  param_idx_t                          first_param_i  = '0;
  param_idx_t                          second_param_i = '0;
  logic signed [qtba_pkg::COEF_W-1:0]  coefficient_i  = '0;
  logic                                last_of_bin_i  = 1'b0;
  logic                                empty;
  logic                                pop            = 1'b0;
  logic signed [qtba_pkg::VALUE_W-1:0] bin_value_o;
  logic [qtba_pkg::BIN_NUM_W-1:0]      bin_number_o;
  logic                                saturated_o;

  // Predictor state: configuration copy and per-bin accumulation
  logic signed [qtba_pkg::COEF_W-1:0] param_q [PARAM_COUNT];
  logic                               start_at_one = 1'b1;
  longint                             bin_sum      = 0;
  logic                               bin_active   = 1'b0;
  int                                 bin_count    = 0;
  logic                               bin_sat      = 1'b0;
  qtba_pkg::result_t                  bin_values_q [$];

  int   fails         = 0;
  int   items_sent    = 0;
  logic idle_on       = 1'b1;
  int   long_hold_len = 0;
  int   long_hold_reqs = 0;

  quadratic_term_bin_accumulator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .first_param_i  (first_param_i),
    .second_param_i (second_param_i),
    .coefficient_i  (coefficient_i),
    .last_of_bin_i  (last_of_bin_i),
    .empty          (empty),
    .pop            (pop),
    .bin_value_o    (bin_value_o),
    .bin_number_o   (bin_number_o),
    .saturated_o    (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAIL quadratic_term_bin_accumulator");
    $finish;
  end

  // Out-of-range parameter indexes read as zero
  function automatic longint param_of(param_idx_t idx);
    if (idx >= PARAM_COUNT) return 0;
    return longint'(param_q[idx]);
  endfunction

  // Add one term to the open bin; close the bin and queue its value when last
  task automatic accumulate_term(input param_idx_t fp, input param_idx_t sp,
                                 input logic signed [qtba_pkg::COEF_W-1:0] coef,
                                 input logic last);
    longint            c;
    longint            prod;
    longint            ph;
    longint            pl;
    longint            t;
    longint            total;
    qtba_pkg::result_t r;
    c = longint'(coef);
    if (!bin_active) begin
      bin_sum    = start_at_one ? longint'(qtba_pkg::ONE_Q24) : 0;
      bin_sat    = 1'b0;
      bin_active = 1'b1;
    end
    if (sp == qtba_pkg::LINEAR_MARK) begin
      t = (c * param_of(fp)) >>> FRAC_BITS;
    end else begin
      // split the Q24 product so that c*p never leaves 64 bits
      prod = (param_of(fp) * param_of(sp)) >>> FRAC_BITS;
      ph   = prod >>> FRAC_BITS;
      pl   = prod - (ph <<< FRAC_BITS);
      t    = c * ph + ((c * pl) >>> FRAC_BITS);
    end
    total = bin_sum + t;
    if (total > SUM_MAX) begin
      total   = SUM_MAX;
      bin_sat = 1'b1;
    end else if (total < SUM_MIN) begin
      total   = SUM_MIN;
      bin_sat = 1'b1;
    end
    bin_sum = total;
    if (last) begin
      r.value  = total[qtba_pkg::VALUE_W-1:0];
      r.number = bin_count[qtba_pkg::BIN_NUM_W-1:0];
      r.sat    = bin_sat;
      bin_values_q = {bin_values_q, r};
      bin_count  = (bin_count == BIN_COUNT - 1) ? 0 : bin_count + 1;
      bin_active = 1'b0;
    end
  endtask

  // Write one register; mirror it in the predictor on the accepted beat
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == qtba_pkg::CFG_INCLUDE_CENTRAL) start_at_one = data[0];
    else if (idx < PARAM_COUNT) param_q[idx] = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offer one term until accepted, then maybe leave a gap
  task automatic send_term(input param_idx_t fp, input param_idx_t sp,
                           input logic signed [qtba_pkg::COEF_W-1:0] coef,
                           input logic last);
    int gap;
    @(negedge clk_i);
    push           = 1'b1;
    first_param_i  = fp;
    second_param_i = sp;
    coefficient_i  = coef;
    last_of_bin_i  = last;
    do @(posedge clk_i); while (full);
    accumulate_term(fp, sp, coef, last);
    items_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_random_term(input logic last);
    param_idx_t                         fp;
    param_idx_t                         sp;
    logic signed [qtba_pkg::COEF_W-1:0] coef;
    if ($urandom_range(0, 15) == 0)
      fp = param_idx_t'($urandom_range(PARAM_COUNT, (1 << qtba_pkg::IDX_W) - 1));
    else
      fp = param_idx_t'($urandom_range(0, PARAM_COUNT - 1));
    sp = ($urandom_range(0, 3) == 0) ? qtba_pkg::LINEAR_MARK : param_idx_t'($urandom());
    case ($urandom_range(0, 9))
      0:       coef = Q_MIN;
      1:       coef = Q_MAX;
      2, 3, 4: coef = int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: coef = $urandom();
    endcase
    send_term(fp, sp, coef, last);
  endtask

  // Stop sending, let every bin come out and the pipeline settle
  task automatic quiesce();
    @(negedge clk_i);
    push = 1'b0;
    while (bin_values_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Reset values: all parameters zero, each bin starts at 1.0
  task automatic test_reset_state();
    send_term(3'd0, qtba_pkg::LINEAR_MARK, Q_MAX, 1'b1);
    send_term(3'd6, 3'd6, Q_MIN, 1'b1);
    quiesce();
  endtask

  // Linear, square and mixed terms, swapped indexes, out-of-range indexes
  task automatic test_term_kinds();
    write_reg(reg_idx_t'(CFG_PARAM_BASE + 0), 32'h0180_0000);
    write_reg(reg_idx_t'(CFG_PARAM_BASE + 1), 32'hfdc0_0000);
    write_reg(reg_idx_t'(CFG_PARAM_BASE + 2), Q_MIN);
    write_reg(reg_idx_t'(CFG_PARAM_BASE + 3), Q_MAX);
    write_reg(reg_idx_t'(CFG_PARAM_BASE + 4), 32'h0000_0001);
    write_reg(reg_idx_t'(CFG_PARAM_BASE + 5), Q_LSB_NEG);
    write_reg(reg_idx_t'(CFG_PARAM_BASE + 6), 32'h1234_5678);
    write_reg(qtba_pkg::CFG_INCLUDE_CENTRAL, 32'hffff_fffe);
    send_term(3'd0, qtba_pkg::LINEAR_MARK, 32'sh0200_0000, 1'b0);
    send_term(3'd0, 3'd1, Q_LSB_NEG, 1'b0);
    send_term(3'd1, 3'd0, Q_LSB_NEG, 1'b1);
    send_term(3'd7, qtba_pkg::LINEAR_MARK, Q_MAX, 1'b0);
    send_term(3'd7, 3'd3, Q_MAX, 1'b0);
    send_term(3'd3, 3'd7, Q_MIN, 1'b0);
    send_term(3'd5, 3'd5, Q_MIN, 1'b1);
    send_term(3'd4, qtba_pkg::LINEAR_MARK, Q_LSB_NEG, 1'b1);
    send_term(3'd6, 3'd1, Q_MINUS_1, 1'b1);
    quiesce();
  endtask

  // Clamp at both ends; the flag holds for the bin and clears on the next
  task automatic test_saturation();
    write_reg(qtba_pkg::CFG_INCLUDE_CENTRAL, 32'h0000_0001);
    repeat (5) send_term(3'd2, 3'd2, Q_MAX, 1'b0);
    send_term(3'd0, qtba_pkg::LINEAR_MARK, Q_MINUS_1, 1'b1);
    repeat (5) send_term(3'd2, 3'd2, Q_MIN, 1'b0);
    send_term(3'd3, 3'd3, Q_MIN, 1'b1);
    send_term(3'd0, qtba_pkg::LINEAR_MARK, Q_ONE, 1'b1);
    quiesce();
  endtask

  // New setting of every register, then random bins of random terms
  task automatic test_random_phase(input param_set_e kind, input int n_items);
    int                                 first_item;
    int                                 len;
    logic signed [qtba_pkg::COEF_W-1:0] v;
    idle_on = 1'b1;
    for (int i = 0; i < PARAM_COUNT; i++) begin
      case (kind)
        SET_EXTREME: v = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        SET_SMALL:   v = int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        default:     v = $urandom();
      endcase
      write_reg(reg_idx_t'(CFG_PARAM_BASE + i), v);
    end
    write_reg(qtba_pkg::CFG_INCLUDE_CENTRAL, $urandom());
    first_item = items_sent;
    while (items_sent - first_item < n_items) begin
      // alternate stretches with and without idling
      if ($urandom_range(0, 31) == 0) idle_on = ~idle_on;
      len = $urandom_range(1, MAX_BIN_TERMS);
      for (int k = 0; k < len; k++) send_random_term(k == len - 1);
    end
    // sometimes carry an open bin across the next register change
    if ($urandom_range(0, 1) == 0) send_random_term(1'b0);
    quiesce();
    idle_on = 1'b1;
  endtask

  // Hold off the result side so the block fills up and stalls its input
  task automatic test_result_backpressure();
    idle_on        = 1'b0;
    long_hold_len  = 300;
    long_hold_reqs = long_hold_reqs + 1;
    repeat (60) send_random_term($urandom_range(0, 3) != 0);
    quiesce();
    idle_on = 1'b1;
  endtask

  // Finish with one-term bins back to back, no idling on either side
  task automatic test_back_to_back_bins();
    idle_on = 1'b0;
    repeat (FINAL_BINS) send_random_term(1'b1);
  endtask

  // Result side: random stall bursts, plus the long hold when requested
  initial begin : result_sink
    int stall_left;
    int holds_seen;
    stall_left = 0;
    holds_seen = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_reqs != holds_seen) begin
        holds_seen = long_hold_reqs;
        stall_left = long_hold_len;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
      end
    end
  end

  // Compare each popped beat with the oldest pending bin
  always @(posedge clk_i) begin : result_check
    qtba_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (bin_values_q.size() == 0) begin
        $error("result beat with no bin pending: bin_number %0d", bin_number_o);
        fails++;
      end else begin
        want = bin_values_q.pop_front();
        if (bin_value_o !== want.value) begin
          $error("bin_value: expected %0d, got %0d", want.value, bin_value_o);
          fails++;
        end
        if (bin_number_o !== want.number) begin
          $error("bin_number: expected %0d, got %0d", want.number, bin_number_o);
          fails++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, saturated_o);
          fails++;
        end
      end
    end
  end

  initial begin
    foreach (param_q[i]) param_q[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_term_kinds();
    test_saturation();
    test_random_phase(SET_WIDE, 400);
    test_result_backpressure();
    test_random_phase(SET_SMALL, 400);
    test_random_phase(SET_EXTREME, 400);
    test_random_phase(SET_WIDE, 400);
    test_back_to_back_bins();
    quiesce();
    if (fails == 0) $display("PASS quadratic_term_bin_accumulator");
    else $display("FAIL quadratic_term_bin_accumulator");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/qtba_pkg.sv
hw/rtl/qtba_fifo.sv
hw/rtl/qtba_front.sv
hw/rtl/qtba_back.sv
hw/rtl/quadratic_term_bin_accumulator.sv
verif/tb.sv
